// ===== hw/rtl/dqm_pkg.sv =====
// Shared types and constants for the double-ended queue with middle report.
// Used by dqm_cell, dqm_chain and deque_with_middle_element; no dependencies.
package dqm_pkg;

	localparam int unsigned DEPTH_DEFAULT = 64;
	localparam int unsigned DATA_W        = 32;

	// Middle value reported when the queue holds nothing.
	localparam logic signed [DATA_W-1:0] EMPTY_MIDDLE = -32'sd1;

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	// Per-chain control, applied at each clock. shr moves every cell one place away
	// from the head (the head takes the feed), shl moves one place toward
	// the head, wr loads the item value into the addressed cell.
	typedef struct packed {
		logic shr;
		logic shl;
		logic wr;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/dqm_cell.sv =====
// One storage cell of a queue half: holds a single value.
// Depends on dqm_pkg for the control struct and data width.
module dqm_cell #(
	parameter int unsigned IDX_W = 1,
	parameter int unsigned INDEX = 0
) (
	input  logic                                 clk,
	input  dqm_pkg::cell_ctl_t                   ctl,
	input  logic [IDX_W-1:0]                     wr_idx,
	input  logic signed [dqm_pkg::DATA_W-1:0]    wr_data,
	input  logic signed [dqm_pkg::DATA_W-1:0]    lo_data,
	input  logic signed [dqm_pkg::DATA_W-1:0]    hi_data,
	output logic signed [dqm_pkg::DATA_W-1:0]    data
);

	logic signed [dqm_pkg::DATA_W-1:0] data_q;
	logic                              hit;

	assign hit  = ctl.wr && (wr_idx == IDX_W'(INDEX));
	assign data = data_q;

	// A write to this cell wins over the shift in the same cycle.
	always_ff @(posedge clk) begin
		if (hit) begin
			data_q <= wr_data;
		end else if (ctl.shr) begin
			data_q <= lo_data;
		end else if (ctl.shl) begin
			data_q <= hi_data;
		end
	end

endmodule

// ===== hw/rtl/dqm_chain.sv =====
// A row of dqm_cell instances forming one half of the queue; cell 0 is the
// end next to the middle. Depends on dqm_pkg and dqm_cell.
module dqm_chain #(
	parameter int unsigned CELLS = 32,
	parameter int unsigned IDX_W = 5
) (
	input  logic                                 clk,
	input  dqm_pkg::cell_ctl_t                   ctl,
	input  logic [IDX_W-1:0]                     wr_idx,
	input  logic signed [dqm_pkg::DATA_W-1:0]    wr_data,
	input  logic signed [dqm_pkg::DATA_W-1:0]    feed,
	output logic signed [dqm_pkg::DATA_W-1:0]    head
);

	logic signed [dqm_pkg::DATA_W-1:0] cell_data [CELLS];

	assign head = cell_data[0];

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		logic signed [dqm_pkg::DATA_W-1:0] lo;
		logic signed [dqm_pkg::DATA_W-1:0] hi;

		if (g == 0) begin : g_lo_feed
			assign lo = feed;
		end else begin : g_lo_nb
			assign lo = cell_data[g-1];
		end

		if (g == CELLS - 1) begin : g_hi_end
			assign hi = '0;
		end else begin : g_hi_nb
			assign hi = cell_data[g+1];
		end

		dqm_cell #(
			.IDX_W (IDX_W),
			.INDEX (g)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.wr_idx  (wr_idx),
			.wr_data (wr_data),
			.lo_data (lo),
			.hi_data (hi),
			.data    (cell_data[g])
		);
	end

endmodule

// ===== hw/rtl/deque_with_middle_element.sv =====
// Top level of the double-ended queue that reports its middle element.
// Depends on dqm_pkg and dqm_chain (which instantiates dqm_cell).
//
//  Channel   Handshake                 Fields
//  --------  ------------------------  -----------------------------------------
//  request   start / busy (busy low)   action, push_value
//  result    done (one-cycle strobe)   middle_value, entry_count, is_empty, status
//
// One item is accepted in every cycle; busy never rises. Its result appears in
// the cycle right after acceptance, marked by done for that single cycle.
// The rate is set by the two cell chains, which update once for each item.
// Reset (arst_n low) empties the queue and clears done; cell contents are not
// cleared since only occupied cells are ever read.
// The receiver cannot stall, so no result is ever held back.
//
// Organization: the queue is split at the middle into two rows of cells.
// Row A holds the floor(count/2) entries before the middle, with the entry
// nearest the middle in its cell 0. Row B holds the rest, so the middle entry
// always sits in B cell 0 and needs no selection. Pushes at either end write
// the far end of one row, pops just shrink the count, and whenever the split
// point moves one entry crosses between the two row heads while both rows
// shift by one place.
module deque_with_middle_element #(
	parameter int unsigned DEPTH = dqm_pkg::DEPTH_DEFAULT,
	localparam int unsigned CNT_W   = $clog2(DEPTH + 1),
	localparam int unsigned A_CELLS = DEPTH / 2,
	localparam int unsigned B_CELLS = DEPTH - DEPTH / 2,
	localparam int unsigned AI_W    = (A_CELLS > 1) ? $clog2(A_CELLS) : 1,
	localparam int unsigned BI_W    = (B_CELLS > 1) ? $clog2(B_CELLS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           action,
	input  logic signed [dqm_pkg::DATA_W-1:0]    push_value,
	output logic                                 done,
	output logic signed [dqm_pkg::DATA_W-1:0]    middle_value,
	output logic [CNT_W-1:0]                     entry_count,
	output logic                                 is_empty,
	output logic [1:0]                           status
);

	logic                              accept;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  count_d;
	logic                              done_q;
	dqm_pkg::status_t                  status_q;
	dqm_pkg::status_t                  status_d;

	logic [CNT_W-1:0]                  a_size;
	logic [CNT_W-1:0]                  b_size;
	logic [CNT_W-1:0]                  a_minus1;
	logic [CNT_W-1:0]                  b_minus1;
	logic                              q_full;
	logic                              q_empty;
	logic                              q_odd;

	dqm_pkg::cell_ctl_t                a_ctl;
	dqm_pkg::cell_ctl_t                b_ctl;
	logic [AI_W-1:0]                   a_idx;
	logic [BI_W-1:0]                   b_idx;
	logic signed [dqm_pkg::DATA_W-1:0] a_head;
	logic signed [dqm_pkg::DATA_W-1:0] b_head;

	// The queue never needs to hold off an item.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Row sizes follow from the count alone.
	assign a_size   = count_q >> 1;
	assign b_size   = count_q - a_size;
	assign a_minus1 = a_size - CNT_W'(1);
	assign b_minus1 = b_size - CNT_W'(1);
	assign q_full   = (count_q == CNT_W'(DEPTH));
	assign q_empty  = (count_q == '0);
	assign q_odd    = count_q[0];

	// Decide how each row moves for the accepted item. An even count means
	// both rows are the same size; an odd count means row B has one more.
	always_comb begin
		a_ctl    = '0;
		b_ctl    = '0;
		a_idx    = a_size[AI_W-1:0];
		b_idx    = b_size[BI_W-1:0];
		count_d  = count_q;
		status_d = dqm_pkg::ST_DONE;

		case (dqm_pkg::action_t'(action))
			dqm_pkg::ACT_PUSH_FRONT: begin
				if (q_full) begin
					status_d = dqm_pkg::ST_PUSH_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					if (q_empty) begin
						// The first item becomes the middle directly.
						b_ctl.wr = 1'b1;
						b_idx    = '0;
					end else if (!q_odd) begin
						// Row A's head moves over to become the new middle,
						// and the new item lands at A's far end.
						a_ctl.shl = 1'b1;
						a_ctl.wr  = 1'b1;
						a_idx     = a_minus1[AI_W-1:0];
						b_ctl.shr = 1'b1;
					end else begin
						a_ctl.wr = 1'b1;
					end
				end
			end
			dqm_pkg::ACT_PUSH_BACK: begin
				if (q_full) begin
					status_d = dqm_pkg::ST_PUSH_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					if (!q_odd) begin
						b_ctl.wr = 1'b1;
					end else begin
						// The old middle moves to A's head; the new item
						// lands at B's far end after B shifts toward its head.
						a_ctl.shr = 1'b1;
						b_ctl.shl = 1'b1;
						b_ctl.wr  = 1'b1;
						b_idx     = b_minus1[BI_W-1:0];
					end
				end
			end
			dqm_pkg::ACT_POP_FRONT: begin
				if (q_empty) begin
					status_d = dqm_pkg::ST_POP_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
					if (q_odd) begin
						// The middle passes to row A as the split moves back.
						a_ctl.shr = 1'b1;
						b_ctl.shl = 1'b1;
					end
				end
			end
			dqm_pkg::ACT_POP_BACK: begin
				if (q_empty) begin
					status_d = dqm_pkg::ST_POP_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
					if (!q_odd) begin
						// Row A's head becomes the new middle.
						a_ctl.shl = 1'b1;
						b_ctl.shr = 1'b1;
					end
				end
			end
			default: begin
				status_d = dqm_pkg::ST_DONE;
			end
		endcase

		if (!accept) begin
			a_ctl   = '0;
			b_ctl   = '0;
			count_d = count_q;
		end
	end

	dqm_chain #(
		.CELLS (A_CELLS),
		.IDX_W (AI_W)
	) u_chain_a (
		.clk     (clk),
		.ctl     (a_ctl),
		.wr_idx  (a_idx),
		.wr_data (push_value),
		.feed    (b_head),
		.head    (a_head)
	);

	dqm_chain #(
		.CELLS (B_CELLS),
		.IDX_W (BI_W)
	) u_chain_b (
		.clk     (clk),
		.ctl     (b_ctl),
		.wr_idx  (b_idx),
		.wr_data (push_value),
		.feed    (a_head),
		.head    (b_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	// The result is read straight off the state registers during the strobe
	// cycle, which always reflects exactly the item just accepted.
	assign done         = done_q;
	assign entry_count  = count_q;
	assign is_empty     = (count_q == '0);
	assign middle_value = (count_q == '0) ? dqm_pkg::EMPTY_MIDDLE : b_head;
	assign status       = status_q;

	// Every accepted item yields exactly one strobe in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted item produced no result strobe");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result strobe without an accepted item");

	// A dropped push or ignored pop leaves the count untouched.
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != dqm_pkg::ST_DONE) |-> (count_q == $past(count_q)))
		else $error("rejected item changed the entry count");

	// A completed operation always moves the count by one.
	a_done_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == dqm_pkg::ST_DONE) |-> (count_q != $past(count_q)))
		else $error("completed item left the entry count unchanged");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

endmodule
